>>> hw/rtl/utf8cd_pkg.sv
`timescale 1ns / 1ps

package utf8cd_pkg;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_CONT     = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEAD = 2'd2;

  // classified byte as it travels from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       string_start;
    logic [2:0] lead_len;   // 0 when the byte cannot open a character
    logic [1:0] lead_status;
  } cls_t;

  localparam int CLS_BITS = $bits(cls_t);

  function automatic logic [7:0] payload_mask(input logic [2:0] len);
    logic [7:0] m;
    begin
      case (len)
        3'd1:    m = 8'b0111_1111;
        3'd2:    m = 8'b0001_1111;
        3'd3:    m = 8'b0000_1111;
        3'd4:    m = 8'b0000_0111;
        3'd5:    m = 8'b0000_0011;
        3'd6:    m = 8'b0000_0001;
        default: m = 8'b0000_0000;
      endcase
      return m;
    end
  endfunction

endpackage

>>> hw/rtl/utf8cd_front.sv
`timescale 1ns / 1ps

module utf8cd_front #(
  parameter int INDEX_BITS = 16
) (
  input  logic [7:0]            in_data_byte,
  input  logic                  in_string_start,
  input  logic [15:0]           in_target_index,
  output utf8cd_pkg::cls_t      cls,
  output logic [INDEX_BITS-1:0] index
);
  import utf8cd_pkg::*;

  logic [INDEX_BITS+15:0] index_ext;

  assign index_ext = {{INDEX_BITS{1'b0}}, in_target_index};
  assign index     = index_ext[INDEX_BITS-1:0];

  always_comb begin
    cls.data_byte    = in_data_byte;
    cls.string_start = in_string_start;
    cls.lead_status  = STATUS_OK;
    case (in_data_byte) inside
      [8'h00:8'h7F]: cls.lead_len = 3'd1;
      [8'h80:8'hBF]: begin
        cls.lead_len    = 3'd0;
        cls.lead_status = STATUS_CONT;
      end
      [8'hC0:8'hDF]: cls.lead_len = 3'd2;
      [8'hE0:8'hEF]: cls.lead_len = 3'd3;
      [8'hF0:8'hF7]: cls.lead_len = 3'd4;
      [8'hF8:8'hFB]: cls.lead_len = 3'd5;
      [8'hFC:8'hFD]: cls.lead_len = 3'd6;
      default: begin
        cls.lead_len    = 3'd0;
        cls.lead_status = STATUS_BAD_LEAD;
      end
    endcase
  end

endmodule

>>> hw/rtl/utf8cd_queue.sv
`timescale 1ns / 1ps

module utf8cd_queue #(
  parameter int WIDTH = 30
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign rd_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> hw/rtl/utf8cd_back.sv
`timescale 1ns / 1ps

module utf8cd_back #(
  parameter int INDEX_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  utf8cd_pkg::cls_t      q_cls,
  input  logic [INDEX_BITS-1:0] q_index,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [30:0]           out_code_point,
  output logic [1:0]            out_status
);
  import utf8cd_pkg::*;

  logic [INDEX_BITS-1:0] chars_passed_r, chars_passed_nxt;
  logic [INDEX_BITS-1:0] target_r, target_nxt;
  logic [2:0]            bytes_to_go_r, bytes_to_go_nxt;
  logic [30:0]           acc_r, acc_nxt;
  logic                  collecting_r, collecting_nxt;
  logic                  finished_r, finished_nxt;
  logic                  out_valid_r;
  logic [30:0]           out_cp_r;
  logic [1:0]            out_st_r;

  logic [INDEX_BITS-1:0] cp_eff, tgt_eff;
  logic [2:0]            btg_eff;
  logic [30:0]           acc_shift;
  logic                  emit;
  logic [30:0]           res_cp;
  logic [1:0]            res_st;

  assign q_pop          = q_valid && (!out_valid_r || !out_stall);
  assign out_valid      = out_valid_r;
  assign out_code_point = out_cp_r;
  assign out_status     = out_st_r;

  assign cp_eff    = q_cls.string_start ? '0 : chars_passed_r;
  assign tgt_eff   = q_cls.string_start ? q_index : target_r;
  assign btg_eff   = q_cls.string_start ? 3'd0 : bytes_to_go_r;
  assign acc_shift = {acc_r[24:0], q_cls.data_byte[5:0]};

  always_comb begin
    chars_passed_nxt = chars_passed_r;
    target_nxt       = target_r;
    bytes_to_go_nxt  = bytes_to_go_r;
    acc_nxt          = acc_r;
    collecting_nxt   = collecting_r;
    finished_nxt     = finished_r;
    emit             = 1'b0;
    res_cp           = '0;
    res_st           = STATUS_OK;
    if (q_pop) begin
      if (q_cls.string_start) begin
        chars_passed_nxt = '0;
        target_nxt       = q_index;
        bytes_to_go_nxt  = 3'd0;
        acc_nxt          = '0;
        collecting_nxt   = 1'b0;
        finished_nxt     = 1'b0;
      end
      if (q_cls.string_start || !finished_r) begin
        if (btg_eff != 3'd0) begin
          bytes_to_go_nxt = btg_eff - 3'd1;
          if (collecting_r) begin
            acc_nxt = acc_shift;
            if (btg_eff == 3'd1) begin
              emit           = 1'b1;
              res_cp         = acc_shift;
              finished_nxt   = 1'b1;
              collecting_nxt = 1'b0;
            end
          end
        end else if (q_cls.lead_len == 3'd0) begin
          acc_nxt         = '0;
          emit            = 1'b1;
          res_st          = q_cls.lead_status;
          finished_nxt    = 1'b1;
          collecting_nxt  = 1'b0;
          bytes_to_go_nxt = 3'd0;
        end else if (cp_eff == tgt_eff) begin
          acc_nxt = {23'd0, q_cls.data_byte & payload_mask(q_cls.lead_len)};
          if (q_cls.lead_len == 3'd1) begin
            emit            = 1'b1;
            res_cp          = {23'd0, q_cls.data_byte & payload_mask(q_cls.lead_len)};
            finished_nxt    = 1'b1;
            collecting_nxt  = 1'b0;
            bytes_to_go_nxt = 3'd0;
          end else begin
            collecting_nxt  = 1'b1;
            bytes_to_go_nxt = q_cls.lead_len - 3'd1;
          end
        end else begin
          chars_passed_nxt = cp_eff + INDEX_BITS'(1);
          bytes_to_go_nxt  = q_cls.lead_len - 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_passed_r <= '0;
      target_r       <= '0;
      bytes_to_go_r  <= 3'd0;
      acc_r          <= '0;
      collecting_r   <= 1'b0;
      finished_r     <= 1'b1;
      out_valid_r    <= 1'b0;
    end else begin
      chars_passed_r <= chars_passed_nxt;
      target_r       <= target_nxt;
      bytes_to_go_r  <= bytes_to_go_nxt;
      acc_r          <= acc_nxt;
      collecting_r   <= collecting_nxt;
      finished_r     <= finished_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_cp_r <= res_cp;
      out_st_r <= res_st;
    end
  end

endmodule

>>> hw/rtl/utf8_char_at_index_decoder_top.sv
`timescale 1ns / 1ps

// Decodes the character at a given index of a UTF-8 string fed one byte per
// request, accepting legacy lead bytes of up to six bytes. The string's first
// byte carries string_start and the wanted index (low INDEX_BITS bits kept).
// At most one result per string: the code point with status ok, or status 1 for a
// continuation byte in lead position and 2 for a 0xFE/0xFF lead, code point
// zero. Continuation bytes are not checked; bytes after the result are
// dropped until the next string start. Sustained rate is one byte per cycle
// while the output is not stalled: a classifier writes each byte into a
// two-entry queue and the decode state machine drains one entry a cycle into
// the output register. A result is registered there after its last byte has
// passed through the queue, and is held while the output is stalled.

module utf8_char_at_index_decoder_top #(
  parameter int INDEX_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_string_start,
  input  logic [15:0] in_target_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] out_code_point,
  output logic [1:0]  out_status
);
  import utf8cd_pkg::*;

  localparam int Q_WIDTH = CLS_BITS + INDEX_BITS;

  cls_t                  front_cls, back_cls;
  logic [INDEX_BITS-1:0] front_index, back_index;
  logic                  q_full, q_valid, q_pop, q_push;
  logic [Q_WIDTH-1:0]    q_rd_data;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  utf8cd_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .in_data_byte   (in_data_byte),
    .in_string_start(in_string_start),
    .in_target_index(in_target_index),
    .cls            (front_cls),
    .index          (front_index)
  );

  utf8cd_queue #(.WIDTH(Q_WIDTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data({front_cls, front_index}),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .rd_data  (q_rd_data)
  );

  assign back_cls   = cls_t'(q_rd_data[Q_WIDTH-1:INDEX_BITS]);
  assign back_index = q_rd_data[INDEX_BITS-1:0];

  utf8cd_back #(.INDEX_BITS(INDEX_BITS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_cls         (back_cls),
    .q_index       (back_index),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_code_point(out_code_point),
    .out_status    (out_status)
  );

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import utf8cd_pkg::*;

  localparam int TARGET_BYTES = 1950;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [7:0]  data;
    logic        start;
    logic [15:0] index;
  } byte_req_t;

  typedef struct {
    logic [30:0] cp;
    logic [1:0]  status;
  } char_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_string_start = 1'b0;
  logic [15:0] in_target_index = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [30:0] out_code_point;
  logic [1:0]  out_status;

  byte_req_t    pending_bytes[$];
  char_result_t awaited_chars[$];

  int total_bytes;
  int bytes_taken;
  int bytes_accepted;
  int strings_seen;
  int chars_checked;
  int error_results;
  int fails;
  int cycles;

  // decoder shadow state
  logic [15:0] chars_done;
  logic [15:0] want_index;
  logic [2:0]  cont_left;
  logic [30:0] cp_acc;
  logic        gathering;
  logic        idle;

  utf8_char_at_index_decoder_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_string_start (in_string_start),
    .in_target_index (in_target_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_point  (out_code_point),
    .out_status      (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [2:0] char_length(input logic [7:0] b);
    if (b <= 8'h7F) return 3'd1;
    if (b <= 8'hBF) return 3'd0;
    if (b <= 8'hDF) return 3'd2;
    if (b <= 8'hEF) return 3'd3;
    if (b <= 8'hF7) return 3'd4;
    if (b <= 8'hFB) return 3'd5;
    if (b <= 8'hFD) return 3'd6;
    return 3'd0;
  endfunction

  function automatic logic [7:0] lead_bits(input logic [2:0] len);
    case (len)
      3'd1:    return 8'h7F;
      3'd2:    return 8'h1F;
      3'd3:    return 8'h0F;
      3'd4:    return 8'h07;
      3'd5:    return 8'h03;
      3'd6:    return 8'h01;
      default: return 8'h00;
    endcase
  endfunction

  function automatic void close_string();
    idle      = 1'b1;
    gathering = 1'b0;
    cont_left = 3'd0;
  endfunction

  // returns 1 when the byte completes a result
  function automatic bit decode_step(input logic [7:0] b, input logic st,
                                     input logic [15:0] idx, output char_result_t r);
    logic [2:0] len;
    r = '{cp: 31'd0, status: STATUS_OK};
    if (st) begin
      chars_done = 16'd0;
      want_index = idx;
      cont_left  = 3'd0;
      cp_acc     = 31'd0;
      gathering  = 1'b0;
      idle       = 1'b0;
    end else if (idle) begin
      return 1'b0;
    end
    if (cont_left != 3'd0) begin
      cont_left = cont_left - 3'd1;
      if (gathering) begin
        cp_acc = {cp_acc[24:0], b[5:0]};
        if (cont_left == 3'd0) begin
          r.cp = cp_acc;
          close_string();
          return 1'b1;
        end
      end
      return 1'b0;
    end
    len = char_length(b);
    if (len == 3'd0) begin
      cp_acc   = 31'd0;
      r.status = (b >= 8'hFE) ? STATUS_BAD_LEAD : STATUS_CONT;
      close_string();
      return 1'b1;
    end
    if (chars_done == want_index) begin
      cp_acc = {23'd0, b & lead_bits(len)};
      if (len == 3'd1) begin
        r.cp = cp_acc;
        close_string();
        return 1'b1;
      end
      gathering = 1'b1;
      cont_left = len - 3'd1;
      return 1'b0;
    end
    chars_done = chars_done + 16'd1;
    cont_left  = len - 3'd1;
    return 1'b0;
  endfunction

  function automatic int phase_now();
    if (total_bytes == 0) return 0;
    return ((bytes_taken * 8) / total_bytes) % 4;
  endfunction

  function automatic int send_gap_pct();
    case (phase_now())
      1:       return 56;
      3:       return 14;
      default: return 0;
    endcase
  endfunction

  function automatic int stall_pct();
    case (phase_now())
      2:       return 56;
      3:       return 14;
      default: return 0;
    endcase
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic st, input logic [15:0] idx);
    byte_req_t q;
    q.data  = b;
    q.start = st;
    q.index = idx;
    pending_bytes.push_back(q);
  endtask

  // one character of random form into str; bad leads now and then
  task automatic make_char(inout logic [7:0] str[$]);
    int len;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      str.push_back(8'h80 | 8'($urandom_range(0, 63)));
      return;
    end
    if (pick < 5) begin
      str.push_back(8'($urandom_range(8'hFE, 8'hFF)));
      return;
    end
    len = $urandom_range(1, 6);
    case (len)
      1: str.push_back(8'($urandom_range(8'h00, 8'h7F)));
      2: str.push_back(8'($urandom_range(8'hC0, 8'hDF)));
      3: str.push_back(8'($urandom_range(8'hE0, 8'hEF)));
      4: str.push_back(8'($urandom_range(8'hF0, 8'hF7)));
      5: str.push_back(8'($urandom_range(8'hF8, 8'hFB)));
      default: str.push_back(8'($urandom_range(8'hFC, 8'hFD)));
    endcase
    for (int k = 1; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) str.push_back(8'($urandom));
      else str.push_back(8'h80 | 8'($urandom_range(0, 63)));
    end
  endtask

  task automatic make_string();
    logic [7:0] str[$];
    logic [15:0] idx;
    int pick;
    int nchars;
    int cut;
    pick = $urandom_range(0, 99);
    if (pick < 80) idx = 16'($urandom_range(0, 4));
    else if (pick < 92) idx = 16'($urandom_range(5, 20));
    else idx = 16'($urandom_range(0, 65535));
    nchars = (idx <= 20) ? int'(idx) + 1 + $urandom_range(0, 2) : $urandom_range(1, 4);
    for (int c = 0; c < nchars; c++) make_char(str);
    if ($urandom_range(0, 9) == 0 && str.size() > 1) begin
      cut = $urandom_range(1, str.size() - 1);
      while (str.size() > cut) void'(str.pop_back());
    end
    foreach (str[k]) queue_byte(str[k], k == 0, k == 0 ? idx : 16'($urandom));
    repeat ($urandom_range(0, 3)) queue_byte(8'($urandom), 1'b0, 16'($urandom));
  endtask

  // request driver
  always @(posedge clk) begin : drv
    char_result_t r;
    byte_req_t q;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        bytes_accepted++;
        if (in_string_start) strings_seen++;
        if (decode_step(in_data_byte, in_string_start, in_target_index, r)) begin
          awaited_chars.push_back(r);
        end
      end
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= send_gap_pct()) begin
          q = pending_bytes.pop_front();
          bytes_taken++;
          in_valid        <= 1'b1;
          in_data_byte    <= q.data;
          in_string_start <= q.start;
          in_target_index <= q.index;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : mon
    char_result_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct());
      if (out_valid && !out_stall) begin
        if (awaited_chars.size() == 0) begin
          $error("unexpected result: code_point %h status %0d", out_code_point, out_status);
          fails++;
        end else begin
          e = awaited_chars.pop_front();
          chars_checked++;
          if (e.status != STATUS_OK) error_results++;
          if (out_code_point !== e.cp) begin
            $error("code_point: expected %h, got %h", e.cp, out_code_point);
            fails++;
          end
          if (out_status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_status);
            fails++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    chars_done = 16'd0;
    want_index = 16'd0;
    cont_left  = 3'd0;
    cp_acc     = 31'd0;
    gathering  = 1'b0;
    idle       = 1'b1;

    // extremes of the single-byte form, top of the two-byte form, idle byte ignored
    queue_byte(8'h00, 1'b1, 16'd0);
    queue_byte(8'h7F, 1'b1, 16'd0);
    queue_byte(8'h55, 1'b0, 16'hFFFF);
    queue_byte(8'hDF, 1'b1, 16'd0);
    queue_byte(8'hBF, 1'b0, 16'd0);
    // six-byte form, unchecked continuations give the top code point
    queue_byte(8'hFD, 1'b1, 16'd0);
    repeat (5) queue_byte(8'hFF, 1'b0, 16'd0);
    // bad leads
    queue_byte(8'hFE, 1'b1, 16'd0);
    queue_byte(8'hFF, 1'b1, 16'd0);
    queue_byte(8'h80, 1'b1, 16'd0);
    queue_byte(8'hBF, 1'b1, 16'd0);
    // stray continuation after a skipped character
    queue_byte(8'h41, 1'b1, 16'd2);
    queue_byte(8'h9A, 1'b0, 16'd0);
    // skip a five-byte character then take the next
    queue_byte(8'hF8, 1'b1, 16'd1);
    repeat (4) queue_byte(8'h3C, 1'b0, 16'd0);
    queue_byte(8'h30, 1'b0, 16'd0);
    // restart mid-character
    queue_byte(8'hE2, 1'b1, 16'd0);
    queue_byte(8'h82, 1'b0, 16'd0);
    queue_byte(8'h41, 1'b1, 16'd0);
    // index never reached, string abandoned
    queue_byte(8'h41, 1'b1, 16'hFFFF);
    queue_byte(8'h42, 1'b0, 16'h0000);

    while (pending_bytes.size() < TARGET_BYTES) make_string();
    total_bytes = pending_bytes.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_accepted < total_bytes) @(posedge clk);
    while (awaited_chars.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d bytes in %0d strings sent under four idling mixes;", bytes_accepted,
             strings_seen);
    $display("%0d results checked, %0d of them error codes", chars_checked, error_results);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
